[rtl/core/md5_pkg.sv]
// md5_pkg: shared types, constants and round tables of the md5 digest core
// no dependencies; imported by md5_message_digest

package md5_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN_LO,
      ST_LEN_HI,
      ST_LOAD,
      ST_ROUND_SUM,
      ST_ROUND_ROT,
      ST_FOLD,
      ST_OUT
   } md5_state_type;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE  = 8'h80;
   localparam logic [5:0] LEN_POS   = 6'd56;
   localparam logic [5:0] LAST_POS  = 6'd63;
   localparam logic [3:0] LEN_LO_WORD = 4'd14;
   localparam logic [3:0] LEN_HI_WORD = 4'd15;
   localparam logic [1:0] LAST_INDEX  = 2'd3;

   // message word used by a round
   function automatic logic [3:0] md5_word_index(input logic [5:0] r);
      logic [3:0] lo;
      lo = r[3:0];
      case (r[5:4])
         2'd0:    md5_word_index = lo;
         2'd1:    md5_word_index = 4'((lo << 2) + lo + 4'd1);
         2'd2:    md5_word_index = 4'((lo << 1) + lo + 4'd5);
         2'd3:    md5_word_index = 4'((lo << 3) - lo);
         default: md5_word_index = lo;
      endcase
   endfunction

   function automatic logic [4:0] md5_rot_amount(input logic [5:0] r);
      case ({r[5:4], r[1:0]})
         4'd0:    md5_rot_amount = 5'd7;
         4'd1:    md5_rot_amount = 5'd12;
         4'd2:    md5_rot_amount = 5'd17;
         4'd3:    md5_rot_amount = 5'd22;
         4'd4:    md5_rot_amount = 5'd5;
         4'd5:    md5_rot_amount = 5'd9;
         4'd6:    md5_rot_amount = 5'd14;
         4'd7:    md5_rot_amount = 5'd20;
         4'd8:    md5_rot_amount = 5'd4;
         4'd9:    md5_rot_amount = 5'd11;
         4'd10:   md5_rot_amount = 5'd16;
         4'd11:   md5_rot_amount = 5'd23;
         4'd12:   md5_rot_amount = 5'd6;
         4'd13:   md5_rot_amount = 5'd10;
         4'd14:   md5_rot_amount = 5'd15;
         4'd15:   md5_rot_amount = 5'd21;
         default: md5_rot_amount = 5'd7;
      endcase
   endfunction

   function automatic logic [31:0] md5_sine(input logic [5:0] r);
      case (r)
         6'd0:  md5_sine = 32'hd76aa478;
         6'd1:  md5_sine = 32'he8c7b756;
         6'd2:  md5_sine = 32'h242070db;
         6'd3:  md5_sine = 32'hc1bdceee;
         6'd4:  md5_sine = 32'hf57c0faf;
         6'd5:  md5_sine = 32'h4787c62a;
         6'd6:  md5_sine = 32'ha8304613;
         6'd7:  md5_sine = 32'hfd469501;
         6'd8:  md5_sine = 32'h698098d8;
         6'd9:  md5_sine = 32'h8b44f7af;
         6'd10: md5_sine = 32'hffff5bb1;
         6'd11: md5_sine = 32'h895cd7be;
         6'd12: md5_sine = 32'h6b901122;
         6'd13: md5_sine = 32'hfd987193;
         6'd14: md5_sine = 32'ha679438e;
         6'd15: md5_sine = 32'h49b40821;
         6'd16: md5_sine = 32'hf61e2562;
         6'd17: md5_sine = 32'hc040b340;
         6'd18: md5_sine = 32'h265e5a51;
         6'd19: md5_sine = 32'he9b6c7aa;
         6'd20: md5_sine = 32'hd62f105d;
         6'd21: md5_sine = 32'h02441453;
         6'd22: md5_sine = 32'hd8a1e681;
         6'd23: md5_sine = 32'he7d3fbc8;
         6'd24: md5_sine = 32'h21e1cde6;
         6'd25: md5_sine = 32'hc33707d6;
         6'd26: md5_sine = 32'hf4d50d87;
         6'd27: md5_sine = 32'h455a14ed;
         6'd28: md5_sine = 32'ha9e3e905;
         6'd29: md5_sine = 32'hfcefa3f8;
         6'd30: md5_sine = 32'h676f02d9;
         6'd31: md5_sine = 32'h8d2a4c8a;
         6'd32: md5_sine = 32'hfffa3942;
         6'd33: md5_sine = 32'h8771f681;
         6'd34: md5_sine = 32'h6d9d6122;
         6'd35: md5_sine = 32'hfde5380c;
         6'd36: md5_sine = 32'ha4beea44;
         6'd37: md5_sine = 32'h4bdecfa9;
         6'd38: md5_sine = 32'hf6bb4b60;
         6'd39: md5_sine = 32'hbebfbc70;
         6'd40: md5_sine = 32'h289b7ec6;
         6'd41: md5_sine = 32'heaa127fa;
         6'd42: md5_sine = 32'hd4ef3085;
         6'd43: md5_sine = 32'h04881d05;
         6'd44: md5_sine = 32'hd9d4d039;
         6'd45: md5_sine = 32'he6db99e5;
         6'd46: md5_sine = 32'h1fa27cf8;
         6'd47: md5_sine = 32'hc4ac5665;
         6'd48: md5_sine = 32'hf4292244;
         6'd49: md5_sine = 32'h432aff97;
         6'd50: md5_sine = 32'hab9423a7;
         6'd51: md5_sine = 32'hfc93a039;
         6'd52: md5_sine = 32'h655b59c3;
         6'd53: md5_sine = 32'h8f0ccc92;
         6'd54: md5_sine = 32'hffeff47d;
         6'd55: md5_sine = 32'h85845dd1;
         6'd56: md5_sine = 32'h6fa87e4f;
         6'd57: md5_sine = 32'hfe2ce6e0;
         6'd58: md5_sine = 32'ha3014314;
         6'd59: md5_sine = 32'h4e0811a1;
         6'd60: md5_sine = 32'hf7537e82;
         6'd61: md5_sine = 32'hbd3af235;
         6'd62: md5_sine = 32'h2ad7d2bb;
         6'd63: md5_sine = 32'heb86d391;
         default: md5_sine = 32'hd76aa478;
      endcase
   endfunction

   function automatic logic [31:0] md5_mix(input logic [1:0] stage, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      case (stage)
         2'd0:    md5_mix = (b & c) | (~b & d);
         2'd1:    md5_mix = (b & d) | (c & ~d);
         2'd2:    md5_mix = b ^ c ^ d;
         2'd3:    md5_mix = c ^ (b | ~d);
         default: md5_mix = b ^ c ^ d;
      endcase
   endfunction

endpackage

[rtl/core/md5_message_digest.sv]
// md5_message_digest: byte-stream md5 core with block store and one shared round unit
// depends on md5_pkg (state type, initial values, round tables)
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_data_byte, req_has_byte, req_end_of_message
// rsp      out  rsp_valid/rsp_ready    rsp_digest_word, rsp_word_index, rsp_last_word
//
// a byte without end marker is taken in the idle state; a byte that fills the block adds a compression
// a compression runs 1 load, 64 rounds on the shared adder and rotator (a sum state, then a
// rotate and add state), 1 fold into the chaining words
// end of message: up to 64 padding bytes, a padding state that only leaves padding, 2 length word
// writes, one or two compressions, then 4 digest words, each held until rsp_ready
// req_ready is high only while idle; synchronous reset restores the initial chain

module md5_message_digest
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   md5_state_type state_ff, state_in;

   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] a_in, b_in, c_in, d_in;
   logic [31:0] sum_ff, sum_in;
   logic [5:0]  round_ff, round_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [31:0] acc_ff, acc_in;
   logic        pad_ff, pad_in;
   logic        first_ff, first_in;
   logic        final_ff, final_in;
   logic [1:0]  out_idx_ff, out_idx_in;

   logic [31:0] block_mem [16];
   logic [31:0] mem_q_ff;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;
   logic [3:0]  rd_addr;

   logic        req_fire;
   logic        rsp_fire;
   logic        ins_en;
   logic [7:0]  ins_byte;
   logic [31:0] ins_word;
   logic        pad_done;
   logic [31:0] rot_src;
   logic [4:0]  rot_n;
   logic [63:0] rot_dbl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_fire  = rsp_valid & rsp_ready;

   assign rsp_digest_word = chain_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == LAST_INDEX);

   assign pad_done = !first_ff && (pos_ff == LEN_POS);

   // padding emits 0x80 once, then zeros
   assign ins_byte = (state_ff == ST_PAD) ? (first_ff ? PAD_BYTE : 8'd0) : req_data_byte;

   // byte lane merge into the word being assembled
   always_comb begin
      case (pos_ff[1:0])
         2'd0:    ins_word = {24'd0, ins_byte};
         2'd1:    ins_word = acc_ff | {16'd0, ins_byte, 8'd0};
         2'd2:    ins_word = acc_ff | {8'd0, ins_byte, 16'd0};
         2'd3:    ins_word = acc_ff | {ins_byte, 24'd0};
         default: ins_word = {24'd0, ins_byte};
      endcase
   end

   // rotate left through a doubled word
   assign rot_src = sum_ff + mem_q_ff;
   assign rot_n   = md5_rot_amount(round_ff);
   assign rot_dbl = {rot_src, rot_src} << rot_n;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_has_byte && pos_ff == LAST_POS) begin
                  state_in = ST_LOAD;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_done) begin
               state_in = ST_LEN_LO;
            end else if (pos_ff == LAST_POS) begin
               state_in = ST_LOAD;
            end
         end
         ST_LEN_LO:    state_in = ST_LEN_HI;
         ST_LEN_HI:    state_in = ST_LOAD;
         ST_LOAD:      state_in = ST_ROUND_SUM;
         ST_ROUND_SUM: state_in = ST_ROUND_ROT;
         ST_ROUND_ROT: begin
            if (round_ff == LAST_POS) begin
               state_in = ST_FOLD;
            end else begin
               state_in = ST_ROUND_SUM;
            end
         end
         ST_FOLD: begin
            if (final_ff) begin
               state_in = ST_OUT;
            end else if (pad_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_fire && out_idx_ff == LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         chain_in[i] = chain_ff[i];
      end
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      d_in       = d_ff;
      sum_in     = sum_ff;
      round_in   = round_ff;
      pos_in     = pos_ff;
      bitlen_in  = bitlen_ff;
      acc_in     = acc_ff;
      pad_in     = pad_ff;
      first_in   = first_ff;
      final_in   = final_ff;
      out_idx_in = out_idx_ff;
      ins_en     = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = pos_ff[5:2];
      wr_data    = ins_word;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ins_en   = req_has_byte;
               pad_in   = req_end_of_message;
               first_in = req_end_of_message;
               if (req_has_byte) begin
                  bitlen_in = bitlen_ff + 64'd8;
               end
            end
         end
         ST_PAD: begin
            if (!pad_done) begin
               ins_en   = 1'b1;
               first_in = 1'b0;
            end
         end
         ST_LEN_LO: begin
            wr_en   = 1'b1;
            wr_addr = LEN_LO_WORD;
            wr_data = bitlen_ff[31:0];
         end
         ST_LEN_HI: begin
            wr_en    = 1'b1;
            wr_addr  = LEN_HI_WORD;
            wr_data  = bitlen_ff[63:32];
            final_in = 1'b1;
         end
         ST_LOAD: begin
            a_in = chain_ff[0];
            b_in = chain_ff[1];
            c_in = chain_ff[2];
            d_in = chain_ff[3];
         end
         ST_ROUND_SUM: begin
            sum_in = a_ff + md5_mix(round_ff[5:4], b_ff, c_ff, d_ff) + md5_sine(round_ff);
         end
         ST_ROUND_ROT: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = b_ff + rot_dbl[63:32];
            round_in = round_ff + 6'd1;
         end
         ST_FOLD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               out_idx_in = out_idx_ff + 2'd1;
               if (out_idx_ff == LAST_INDEX) begin
                  chain_in[0] = INIT_A;
                  chain_in[1] = INIT_B;
                  chain_in[2] = INIT_C;
                  chain_in[3] = INIT_D;
                  pos_in      = '0;
                  bitlen_in   = '0;
                  pad_in      = 1'b0;
                  final_in    = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      if (ins_en) begin
         acc_in = ins_word;
         pos_in = pos_ff + 6'd1;
         wr_en  = (pos_ff[1:0] == 2'd3);
      end
   end

   // read for the round about to run; the store is never written during rounds
   assign rd_addr = md5_word_index(round_in);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_mem[wr_addr] <= wr_data;
      end
      mem_q_ff <= block_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      sum_ff <= sum_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff[0] <= INIT_A;
         chain_ff[1] <= INIT_B;
         chain_ff[2] <= INIT_C;
         chain_ff[3] <= INIT_D;
         round_ff    <= '0;
         pos_ff      <= '0;
         bitlen_ff   <= '0;
         pad_ff      <= 1'b0;
         first_ff    <= 1'b0;
         final_ff    <= 1'b0;
         out_idx_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         for (int i = 0; i < 4; i++) begin
            chain_ff[i] <= chain_in[i];
         end
         round_ff   <= round_in;
         pos_ff     <= pos_in;
         bitlen_ff  <= bitlen_in;
         pad_ff     <= pad_in;
         first_ff   <= first_in;
         final_ff   <= final_in;
         out_idx_ff <= out_idx_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while digest words pending");

   a_fold_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FOLD) |-> (round_ff == 6'd0))
      else $error("round counter not wrapped at fold");

   a_load_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (pos_ff == 6'd0 || pos_ff == LEN_POS))
      else $error("compression started on a partial block");

   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN_LO) |-> (pos_ff == LEN_POS && pad_ff && !first_ff))
      else $error("length written at wrong position");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_word) |=> (req_ready && pos_ff == 6'd0 && bitlen_ff == 64'd0))
      else $error("message state not cleared after digest");
`endif

endmodule

[tb/md5_message_digest_tb.sv]
// md5_message_digest_tb: self-checking testbench for the byte-stream md5 core
// depends on md5_pkg (initial chaining values, pad byte, length word indexes)
// and on rtl md5_message_digest

`timescale 1ns / 100ps

module md5_message_digest_tb
   import md5_pkg::*;
();

   localparam int IDLE_LIMIT    = 5000;  // cycles with no word moved on either side
   localparam int SETTLE_CYCLES = 400;   // covers two compressions plus padding
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int ITEM_TARGET   = 450;

   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int ROT_SH [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

   // message lengths around the padding and block boundaries
   localparam int EDGE_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_last_word;

   // digest predictor state
   logic [31:0] chain_word [4];
   logic [31:0] blk_word [16];
   logic [5:0]  fill_pos;
   logic [63:0] msg_bits;

   digest_entry_type digest_q [$];

   int  mismatch_count = 0;
   int  items_sent = 0;
   int  idle_cycles = 0;
   int  sink_hold = 0;
   bit  src_burst = 1'b0;
   bit  sink_burst = 1'b0;

   md5_message_digest DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_digest_word    (rsp_digest_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 0;
   end

   function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void restart_digest();
      chain_word[0] = INIT_A;
      chain_word[1] = INIT_B;
      chain_word[2] = INIT_C;
      chain_word[3] = INIT_D;
      fill_pos      = '0;
      msg_bits      = '0;
   endfunction

   function automatic void md5_compress();
      logic [31:0] a, b, c, d, f, t, sum;
      int r, g, stage;
      a = chain_word[0];
      b = chain_word[1];
      c = chain_word[2];
      d = chain_word[3];
      for (r = 0; r < 64; r++) begin
         stage = r / 16;
         case (stage)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         sum = a + f + SINE_K[r] + blk_word[g];
         t = d;
         d = c;
         c = b;
         b = b + rol32(sum, ROT_SH[stage * 4 + r % 4]);
         a = t;
      end
      chain_word[0] += a;
      chain_word[1] += b;
      chain_word[2] += c;
      chain_word[3] += d;
   endfunction

   // bytes go in little-endian; a byte at a word's low lane clears the word
   function automatic void absorb_byte(input logic [7:0] b);
      int w, sh;
      w  = fill_pos[5:2];
      sh = fill_pos[1:0] * 8;
      if (fill_pos[1:0] == 2'd0)
         blk_word[w] = {24'h0, b};
      else
         blk_word[w][sh +: 8] = b;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0)
         md5_compress();
   endfunction

   function automatic void predict_item(input logic [7:0] data, input logic has,
                                        input logic fin);
      digest_entry_type e;
      int k;
      if (has) begin
         absorb_byte(data);
         msg_bits = msg_bits + 64'd8;
      end
      if (fin) begin
         absorb_byte(PAD_BYTE);
         while (fill_pos != LEN_POS)
            absorb_byte(8'h00);
         blk_word[LEN_LO_WORD] = msg_bits[31:0];
         blk_word[LEN_HI_WORD] = msg_bits[63:32];
         md5_compress();
         for (k = 0; k < 4; k++) begin
            e.word  = chain_word[k];
            e.index = 2'(k);
            e.last  = (2'(k) == LAST_INDEX);
            digest_q.push_back(e);
         end
         restart_digest();
      end
   endfunction

   // valid stays high across back-to-back words, so it is lowered only for a gap
   task automatic send_item(input logic [7:0] data, input logic has, input logic fin);
      int gap;
      gap = src_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_data_byte      <= data;
      req_has_byte       <= has;
      req_end_of_message <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(data, has, fin);
      if (has || fin)
         items_sent++;
   endtask

   task automatic send_message(input int len);
      logic end_on_byte;
      int i;
      end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
         // ignored word: no byte, no end marker
         if ($urandom_range(0, 15) == 0)
            send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte)
         send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_items();
      send_item(8'h00, 1'b0, 1'b1);   // empty message
      send_item(8'hff, 1'b0, 1'b1);   // empty again, junk on the data lane
      send_item(8'h5a, 1'b0, 1'b0);   // ignored
      send_item(8'h00, 1'b1, 1'b1);   // one byte, end on the byte
      send_item(8'hff, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);   // end marker after the byte
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'hff, 1'b0, 1'b0);   // ignored inside a message
      send_item(8'h7f, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b0);
      send_item(8'hfe, 1'b1, 1'b1);
      send_item(8'ha5, 1'b0, 1'b1);   // empty right after a digest
   endtask

   // receiver holds off while the sender keeps offering, so the core backs up
   task automatic test_output_stall();
      int m;
      sink_hold = HOLD_CYCLES;
      src_burst = 1'b1;
      for (m = 0; m < 4; m++)
         send_message($urandom_range(0, 6));
      src_burst = 1'b0;
   endtask

   task automatic test_drain_pause();
      int m;
      for (m = 0; m < 4; m++) begin
         send_message($urandom_range(0, 10));
         wait_for_drain();
      end
   endtask

   task automatic test_random_messages();
      int pick, len;
      while (items_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 65)
            len = $urandom_range(0, 15);
         else if (pick < 85)
            len = EDGE_LEN[$urandom_range(0, 7)];
         else
            len = $urandom_range(0, 140);
         if ($urandom_range(0, 5) == 0)
            src_burst = !src_burst;
         if ($urandom_range(0, 5) == 0)
            sink_burst = !sink_burst;
         send_message(len);
      end
      src_burst  = 1'b0;
      sink_burst = 1'b0;
   endtask

   initial begin
      restart_digest();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_corner_items();
      test_output_stall();
      test_drain_pause();
      test_random_messages();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && digest_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // receiver: per word stall drawn after valid shows, plus an optional long hold
   initial begin : sink
      int wait_n, hold_n;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold > 0) begin
            hold_n    = sink_hold;
            sink_hold = 0;
            rsp_ready <= 1'b0;
            repeat (hold_n) @(posedge clock);
         end
         wait_n = sink_burst ? 0 : $urandom_range(0, 6);
         if (wait_n > 0) begin
            rsp_ready <= 1'b0;
            @(posedge clock);
            while (!rsp_valid) @(posedge clock);
            repeat (wait_n - 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      digest_entry_type exp_e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest word %h index %0d last %b",
                        rsp_digest_word, rsp_word_index, rsp_last_word);
         end else begin
            exp_e = digest_q.pop_front();
            if (rsp_digest_word !== exp_e.word || rsp_word_index !== exp_e.index ||
                rsp_last_word !== exp_e.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                           exp_e.word, exp_e.index, exp_e.last,
                           rsp_digest_word, rsp_word_index, rsp_last_word);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
